FILE: hdl/bgd_pkg.sv
// Package for the button gesture detector: sizes, register indexes,
// sequencer states and the result record.
// No dependencies.
package bgd_pkg;

  // Default build parameters
  localparam int BGD_SLOTS      = 4;
  localparam int BGD_TICK_WIDTH = 32;

  // Number of slots that have configuration registers
  localparam int BGD_REG_SLOTS  = 4;
  localparam int BGD_REG_IDX_W  = 2;

  // Field widths
  localparam int BGD_TIME_W     = 32;
  localparam int BGD_DELAY_W    = 16;
  localparam int BGD_COUNT_W    = 8;
  localparam int BGD_CFG_IDX_W  = 3;
  localparam int BGD_CFG_DATA_W = 32;

  // Configuration register indexes
  typedef enum logic [BGD_CFG_IDX_W-1:0] {
    REG_SLOT_ENABLE  = 3'd0,
    REG_SLOT_DELAY_A = 3'd1,
    REG_SLOT_DELAY_B = 3'd2,
    REG_SLOT_DELAY_C = 3'd3,
    REG_SLOT_DELAY_D = 3'd4,
    REG_SLOT_COUNTS  = 3'd5
  } bgd_reg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } bgd_state_t;

  // One result item
  typedef struct packed {
    logic                  released;
    logic [BGD_TIME_W-1:0] press_duration;
    logic                  fired;
    logic [1:0]            fired_slot;
  } bgd_result_t;

endpackage

FILE: hdl/bgd_if.sv
// Handshake channels of the button gesture detector: edge input,
// result output and configuration write.
// Depends on bgd_pkg.
interface bgd_in_if;
  logic                          valid;
  logic                          ready;
  logic [bgd_pkg::BGD_TIME_W-1:0] edge_time;

  modport source (output valid, output edge_time, input ready);
  modport sink   (input valid, input edge_time, output ready);
endinterface

interface bgd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          released;
  logic [bgd_pkg::BGD_TIME_W-1:0] press_duration;
  logic                          fired;
  logic [1:0]                    fired_slot;

  modport source (output valid, output released, output press_duration,
                  output fired, output fired_slot, input ready);
  modport sink   (input valid, input released, input press_duration,
                  input fired, input fired_slot, output ready);
endinterface

interface bgd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bgd_pkg::BGD_CFG_IDX_W-1:0]  index;
  logic [bgd_pkg::BGD_CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/button_gesture_detector_unit.sv
// Button gesture detector top level: multi-press and long-press slots.
// Depends on bgd_pkg and the channel interfaces in bgd_if.sv.
//
//   channel     dir  payload                                           
//   edge_in     in   edge_time                                         
//   result_out  out  released, press_duration, fired, fired_slot       
//   cfg         in   index, data (always ready)                        
//
// Press: result loaded into the output register in the finish state; next
// edge taken only back in idle. Release: walks the slots, a read then an
// evaluation each (with a write for multi-press slots), then finishes the
// same way; the walk stops at the first slot that fires.
// Reset clears control state and the memory's valid bits at once, no clearing
// pass. A stalled output holds the next result in the finish state.
module button_gesture_detector_unit #(
  parameter int SLOTS      = bgd_pkg::BGD_SLOTS,
  parameter int TICK_WIDTH = bgd_pkg::BGD_TICK_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  bgd_in_if.sink    edge_in,
  bgd_out_if.source result_out,
  bgd_cfg_if.sink   cfg
);
  import bgd_pkg::*;

  localparam int NS    = (SLOTS < BGD_REG_SLOTS) ? SLOTS : BGD_REG_SLOTS;
  localparam int IDX_W = (NS > 1) ? $clog2(NS) : 1;
  localparam int TW    = TICK_WIDTH;
  localparam int ENT_W = 1 + BGD_COUNT_W + TW;

  // Configuration registers
  logic [BGD_REG_SLOTS-1:0]         slot_enable;
  logic [BGD_DELAY_W-1:0]           slot_delay [BGD_REG_SLOTS];
  logic [BGD_REG_SLOTS*BGD_COUNT_W-1:0] slot_counts;

  // Control and datapath registers
  bgd_state_t     state, state_next;
  logic           button_down;
  logic [TW-1:0]  press_start;
  logic [TW-1:0]  t_now;
  logic [TW-1:0]  t_dur;
  logic [IDX_W-1:0] slot_idx;
  bgd_result_t    pend;
  bgd_result_t    out_res;
  logic           out_valid;

  // Slot memory: {window_open, press_count, window_start}
  logic [ENT_W-1:0] slot_mem [NS];
  logic [NS-1:0]    ent_valid;
  logic [ENT_W-1:0] rdata;
  logic             rd_valid;

  // Combinational signals
  logic             in_take;
  logic             load_out;
  logic [TW-1:0]    now_in;
  logic [TW-1:0]    dur_in;
  logic [BGD_REG_IDX_W-1:0] sel;
  logic             sel_en;
  logic [BGD_COUNT_W-1:0] target;
  logic [TW-1:0]    delay_t;
  logic             e_open;
  logic [BGD_COUNT_W-1:0] e_cnt;
  logic [TW-1:0]    e_start;
  logic [TW-1:0]    st_eff;
  logic [TW-1:0]    diff;
  logic [BGD_COUNT_W-1:0] cnt_inc;
  logic             mem_we;
  logic [ENT_W-1:0] mem_wdata;
  logic             slot_fire;
  logic             last_slot;
  logic             eval_done;

  // Configuration writes; indexes beyond the list are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_enable <= '0;
      slot_counts <= '0;
      for (int k = 0; k < BGD_REG_SLOTS; k++) begin
        slot_delay[k] <= '0;
      end
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SLOT_ENABLE:  slot_enable   <= cfg.data[BGD_REG_SLOTS-1:0];
        REG_SLOT_DELAY_A: slot_delay[0] <= cfg.data[BGD_DELAY_W-1:0];
        REG_SLOT_DELAY_B: slot_delay[1] <= cfg.data[BGD_DELAY_W-1:0];
        REG_SLOT_DELAY_C: slot_delay[2] <= cfg.data[BGD_DELAY_W-1:0];
        REG_SLOT_DELAY_D: slot_delay[3] <= cfg.data[BGD_DELAY_W-1:0];
        REG_SLOT_COUNTS:  slot_counts   <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input timing
  assign now_in = TW'(edge_in.edge_time);
  assign dur_in = now_in - press_start;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (edge_in.valid) begin
          state_next = button_down ? ST_READ : ST_FINISH;
        end
      end
      ST_READ:   state_next = ST_EVAL;
      ST_EVAL:   state_next = eval_done ? ST_FINISH : ST_READ;
      ST_FINISH: begin
        if (!out_valid || result_out.ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    edge_in.ready = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      ST_IDLE:   edge_in.ready = 1'b1;
      ST_FINISH: load_out      = !out_valid || result_out.ready;
      default: ;
    endcase
  end

  assign in_take = edge_in.valid && edge_in.ready;

  // Slot evaluation on the entry read in the previous cycle
  always_comb begin
    sel       = BGD_REG_IDX_W'(slot_idx);
    sel_en    = slot_enable[sel];
    target    = slot_counts[sel*BGD_COUNT_W +: BGD_COUNT_W];
    delay_t   = TW'(slot_delay[sel]);
    e_open    = rd_valid & rdata[ENT_W-1];
    e_cnt     = rd_valid ? rdata[TW +: BGD_COUNT_W] : '0;
    e_start   = rd_valid ? rdata[TW-1:0] : '0;
    st_eff    = e_open ? e_start : t_now;
    diff      = t_now - st_eff;
    cnt_inc   = e_cnt + 1'b1;
    mem_we    = 1'b0;
    mem_wdata = '0;
    slot_fire = 1'b0;
    if (state == ST_EVAL && sel_en) begin
      if (target != '0) begin
        // multi-press slot: count inside the window, else close it
        mem_we = 1'b1;
        if (diff <= delay_t) begin
          if (cnt_inc == target) begin
            slot_fire = 1'b1;
          end else begin
            mem_wdata = {1'b1, cnt_inc, st_eff};
          end
        end
      end else if (t_dur >= delay_t) begin
        // long-press slot
        slot_fire = 1'b1;
      end
    end
    last_slot = (slot_idx == IDX_W'(NS - 1));
    eval_done = slot_fire || last_slot;
  end

  // Slot memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[slot_idx] <= mem_wdata;
    end
    if (state == ST_READ) begin
      rdata    <= slot_mem[slot_idx];
      rd_valid <= ent_valid[slot_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (mem_we) begin
      ent_valid[slot_idx] <= 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      button_down <= 1'b0;
      press_start <= '0;
      out_valid   <= 1'b0;
      slot_idx    <= '0;
    end else begin
      state <= state_next;
      if (in_take) begin
        button_down <= !button_down;
        slot_idx    <= '0;
        if (!button_down) begin
          press_start <= now_in;
        end
      end else if (state == ST_EVAL && !eval_done) begin
        slot_idx <= slot_idx + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Pending and output result
  always_ff @(posedge clk) begin
    if (in_take) begin
      t_now               <= now_in;
      t_dur               <= dur_in;
      pend.released       <= button_down;
      pend.press_duration <= button_down ? BGD_TIME_W'(dur_in) : '0;
      pend.fired          <= 1'b0;
      pend.fired_slot     <= '0;
    end else if (slot_fire) begin
      pend.fired      <= 1'b1;
      pend.fired_slot <= 2'(slot_idx);
    end
    if (load_out) begin
      out_res <= pend;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.released       = out_res.released;
  assign result_out.press_duration = out_res.press_duration;
  assign result_out.fired          = out_res.fired;
  assign result_out.fired_slot     = out_res.fired_slot;

`ifndef SYNTHESIS
  // A fire only ever comes with a release
  a_fire_on_release: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> (!result_out.fired || result_out.released))
    else $error("fired result on a press item");

  // Press results carry no duration and no slot
  a_press_clean: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.released) |->
      (result_out.press_duration == '0 && result_out.fired_slot == '0))
    else $error("press result carries data");

  // Walk never runs past the last slot
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot_idx <= IDX_W'(NS - 1))
    else $error("slot index out of range");

  // An accepted item always starts the sequencer
  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_READ || state == ST_FINISH))
    else $error("accepted item not processed");

  // Memory writes only follow a read of the same slot
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ($past(state) == ST_READ && $stable(slot_idx)))
    else $error("slot write without a matching read");
`endif

endmodule

FILE: sim/button_gesture_detector_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_gesture_detector_unit: button edges go in,
// and a local gesture predictor checks every result item field by field.
// Depends on bgd_pkg, the channel interfaces in bgd_if.sv and the RTL top level.
module button_gesture_detector_unit_test;
  import bgd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 300;
  localparam int PRINT_CAP    = 20;

  logic clk = 1'b0;
  logic rst;

  bgd_in_if  edge_if ();
  bgd_out_if res_if ();
  bgd_cfg_if cfg_if ();

  button_gesture_detector_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .edge_in    (edge_if),
    .result_out (res_if),
    .cfg        (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor copy of the configuration registers
  logic [3:0]  cfg_enable;
  logic [15:0] cfg_delay [4];
  logic [31:0] cfg_counts;

  // Predictor copy of the gesture state
  logic        btn_down;
  logic [31:0] press_start;
  logic [31:0] win_start [4];
  logic        win_open  [4];
  logic [7:0]  press_cnt [4];

  bgd_result_t expected_results[$];

  int  edges_sent;
  int  results_checked;
  int  fires_expected;
  int  reg_writes;
  int  mismatch_count;
  int  cycle_count;
  bit  idle_on;
  bit  stall_on;
  logic hold_req;

  // Gesture predictor: one edge in, one expected result out
  function automatic bgd_result_t gesture_predict(input logic [31:0] t);
    bgd_result_t r;
    logic [31:0] held;
    logic [7:0]  target;
    logic        done;
    r = '0;
    done = 1'b0;
    btn_down = !btn_down;
    if (btn_down) begin
      press_start = t;
    end else begin
      held = t - press_start;
      r.released = 1'b1;
      r.press_duration = held;
      // walk enabled slots in order, first to fire wins
      for (int i = 0; i < 4; i++) begin
        if (!done && cfg_enable[i]) begin
          target = cfg_counts[8*i +: 8];
          if (target != 8'd0) begin
            if (!win_open[i]) begin
              win_open[i] = 1'b1;
              win_start[i] = t;
            end
            if ((t - win_start[i]) <= {16'd0, cfg_delay[i]}) begin
              press_cnt[i] = press_cnt[i] + 8'd1;
              if (press_cnt[i] == target) begin
                press_cnt[i] = 8'd0;
                win_open[i] = 1'b0;
                win_start[i] = 32'd0;
                r.fired = 1'b1;
                r.fired_slot = 2'(i);
                done = 1'b1;
              end
            end else begin
              // window expired: drop the count without counting this one
              press_cnt[i] = 8'd0;
              win_open[i] = 1'b0;
              win_start[i] = 32'd0;
            end
          end else if (held >= {16'd0, cfg_delay[i]}) begin
            r.fired = 1'b1;
            r.fired_slot = 2'(i);
            done = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] mismatch on %s: got %h, expected %h (result %0d)",
               $realtime, what, got, want, results_checked);
  endtask

  // Send one edge item; valid is left high for a following item
  task automatic send_edge(input logic [31:0] t);
    bgd_result_t want;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      edge_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    edge_if.valid <= 1'b1;
    edge_if.edge_time <= t;
    @(posedge clk);
    while (!edge_if.ready) @(posedge clk);
    want = gesture_predict(t);
    expected_results.push_back(want);
    edges_sent++;
    if (want.fired) fires_expected++;
  endtask

  task automatic send_pair(input logic [31:0] press_t, input logic [31:0] release_t);
    send_edge(press_t);
    send_edge(release_t);
  endtask

  // Register write; valid stays high so writes can go back to back
  task automatic write_reg(input bgd_reg_t idx, input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_SLOT_ENABLE:  cfg_enable = val[3:0];
      REG_SLOT_DELAY_A: cfg_delay[0] = val[15:0];
      REG_SLOT_DELAY_B: cfg_delay[1] = val[15:0];
      REG_SLOT_DELAY_C: cfg_delay[2] = val[15:0];
      REG_SLOT_DELAY_D: cfg_delay[3] = val[15:0];
      REG_SLOT_COUNTS:  cfg_counts = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Write every register; unused upper data bits carry noise
  task automatic set_config(input logic [3:0] en, input logic [15:0] da,
                            input logic [15:0] db, input logic [15:0] dc,
                            input logic [15:0] dd, input logic [31:0] counts);
    write_reg(REG_SLOT_ENABLE,  ($urandom & 32'hFFFF_FFF0) | {28'd0, en});
    write_reg(REG_SLOT_DELAY_A, ($urandom & 32'hFFFF_0000) | {16'd0, da});
    write_reg(REG_SLOT_DELAY_B, ($urandom & 32'hFFFF_0000) | {16'd0, db});
    write_reg(REG_SLOT_DELAY_C, ($urandom & 32'hFFFF_0000) | {16'd0, dc});
    write_reg(REG_SLOT_DELAY_D, ($urandom & 32'hFFFF_0000) | {16'd0, dd});
    write_reg(REG_SLOT_COUNTS,  counts);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Block idle: all results back, then let the pipeline settle
  task automatic wait_idle();
    edge_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_delay();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 64));
      3:       return 16'($urandom_range(1, 2000));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [31:0] rand_counts();
    logic [31:0] c;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 3))
        0:       c[8*i +: 8] = 8'd0;
        1, 2:    c[8*i +: 8] = 8'($urandom_range(1, 4));
        default: c[8*i +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return c;
  endfunction

  // Hold or gap length, often close to a configured delay
  function automatic logic [31:0] pick_span();
    case ($urandom_range(0, 5))
      0:       return 32'($urandom_range(0, 8));
      1:       return 32'($urandom_range(0, 200));
      2:       return {16'd0, cfg_delay[$urandom_range(0, 3)]} +
                      32'($urandom_range(0, 2)) - 32'd1;
      3:       return 32'($urandom_range(0, 70000));
      4:       return 32'($urandom_range(0, 2000));
      default: return $urandom;
    endcase
  endfunction

  // Registers at reset value: nothing enabled, nothing fires
  task automatic test_reset_state();
    send_pair(32'd0, 32'hFFFF_FFFF);
  endtask

  // Long-press thresholds at the extremes, priority and tick wraparound
  task automatic test_long_press();
    wait_idle();
    set_config(4'b1101, 16'hFFFF, 16'd0, 16'd100, 16'd5, 32'd0);
    send_pair(32'd1000, 32'd1000 + 32'd65535);
    send_pair(32'd200000, 32'd200000 + 32'd65534);
    send_pair(32'd300000, 32'd300100);
    send_pair(32'd400000, 32'd400099);
    send_pair(32'd500000, 32'd500005);
    send_pair(32'd600000, 32'd600004);
    send_pair(32'hFFFF_FFF0, 32'h0000_0070);
  endtask

  // Double press inside the window fires; a late press resets the slot
  task automatic test_multi_press();
    wait_idle();
    set_config(4'b0001, 16'd50, 16'd0, 16'd0, 16'd0, 32'h0000_0002);
    send_pair(32'd990, 32'd1000);
    send_pair(32'd1020, 32'd1040);
    send_pair(32'd1990, 32'd2000);
    send_pair(32'd2040, 32'd2051);
    send_pair(32'd2055, 32'd2060);
  endtask

  // Earlier slot firing stops the walk before later slots are touched
  task automatic test_slot_priority();
    wait_idle();
    set_config(4'hF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 32'h0001_0003);
    send_pair(32'd10, 32'd20);
    send_pair(32'd30, 32'd40);
    send_pair(32'd50, 32'd60);
  endtask

  // Target lowered below a running count: count wraps before it matches
  task automatic test_count_retarget();
    logic [31:0] t;
    wait_idle();
    set_config(4'b0001, 16'hFFFF, 16'd0, 16'd0, 16'd0, 32'd3);
    t = 32'h0000_1000;
    send_pair(t, t);
    send_pair(t + 32'd1, t + 32'd2);
    wait_idle();
    set_config(4'b0001, 16'hFFFF, 16'd0, 16'd0, 16'd0, 32'd1);
    for (int k = 0; k < 255; k++) begin
      t = t + 32'($urandom_range(0, 100));
      send_pair(t, t + 32'($urandom_range(0, 20)));
    end
  endtask

  // Output held off for a long stretch while edges keep coming
  task automatic test_backpressure();
    wait_idle();
    set_config(4'b0011, 16'd40, 16'd300, 16'd0, 16'd0, 32'h0000_0002);
    idle_on = 1'b0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int k = 0; k < 20; k++)
      send_pair(32'(k * 1000), 32'(k * 1000 + $urandom_range(0, 600)));
  endtask

  // Random configurations, mostly press/release pairs with some stray edges
  task automatic test_random_gestures(input int phases, input int per_phase);
    logic [31:0] t;
    logic [31:0] hold;
    int n;
    for (int p = 0; p < phases; p++) begin
      wait_idle();
      if (p < phases - 3) begin
        idle_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end else begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      case (p)
        0:       set_config(4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        1:       set_config(4'hF, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0);
        default: set_config(4'($urandom_range(0, 15)), rand_delay(), rand_delay(),
                            rand_delay(), rand_delay(), rand_counts());
      endcase
      t = $urandom;
      n = 0;
      while (n < per_phase) begin
        case ($urandom_range(0, 9))
          0: begin
            send_edge($urandom);
            n++;
          end
          1: begin
            send_pair($urandom, $urandom);
            n += 2;
          end
          default: begin
            // realign so the pair is a press then a release
            if (btn_down) begin
              send_edge(t);
              n++;
            end
            hold = pick_span();
            send_pair(t, t + hold);
            t = t + hold + pick_span();
            n += 2;
          end
        endcase
      end
    end
  endtask

  // Result receiver: random stalls plus one long hold on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req)
        stall_left = LONG_HOLD;
      else if (stall_left == 0 && stall_on && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 15);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    bgd_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", res_if.press_duration, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (res_if.released !== want.released)
          report_mismatch("released", 32'(res_if.released), 32'(want.released));
        if (res_if.press_duration !== want.press_duration)
          report_mismatch("press_duration", res_if.press_duration, want.press_duration);
        if (res_if.fired !== want.fired)
          report_mismatch("fired", 32'(res_if.fired), 32'(want.fired));
        if (res_if.fired_slot !== want.fired_slot)
          report_mismatch("fired_slot", 32'(res_if.fired_slot), 32'(want.fired_slot));
      end
      results_checked++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("button_gesture_detector_unit_test: FAIL");
      $finish;
    end
  end

  initial begin
    cfg_enable = 4'd0;
    cfg_counts = 32'd0;
    btn_down = 1'b0;
    press_start = 32'd0;
    for (int i = 0; i < 4; i++) begin
      cfg_delay[i] = 16'd0;
      win_start[i] = 32'd0;
      win_open[i] = 1'b0;
      press_cnt[i] = 8'd0;
    end
    edges_sent = 0;
    results_checked = 0;
    fires_expected = 0;
    reg_writes = 0;
    mismatch_count = 0;
    cycle_count = 0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    hold_req <= 1'b0;
    edge_if.valid <= 1'b0;
    edge_if.edge_time <= 32'd0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_SLOT_ENABLE;
    cfg_if.data <= 32'd0;
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_long_press();
    test_multi_press();
    test_slot_priority();
    test_count_retarget();
    test_backpressure();
    test_random_gestures(12, 116);

    wait_idle();
    $display("covered: %0d edges, %0d results checked, %0d slot fires, %0d register writes",
             edges_sent, results_checked, fires_expected, reg_writes);
    $display("long-press and multi-press slots, retargeted counts, tick wrap, long output hold");
    if (mismatch_count == 0)
      $display("button_gesture_detector_unit_test: PASS");
    else
      $display("button_gesture_detector_unit_test: FAIL");
    $finish;
  end

endmodule
